FILE: rtl/cwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwt_pkg
// Shared types and codes for the countdown wakeup timer table.
// ----------------------------------------------------------------------------
package cwt_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    localparam int OP_W   = 2;
    localparam int PID_W  = 8;
    localparam int TICK_W = 32;
    localparam int KIND_W = 2;

    localparam logic [OP_W-1:0] OP_SLEEP = 2'd0;
    localparam logic [OP_W-1:0] OP_ALARM = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_HELD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WAKE = 2'd2;

    typedef struct packed {
        logic capture;   // latch input beat, restart scan pointers
        logic reg_do;    // perform registration, load result
        logic rd_en;     // read table at scan pointer, advance it
        logic eval_en;   // read data holds an entry to evaluate
        logic flush;     // end of scan: commit count, emit final wake
    } t_cmd;

    typedef struct packed {
        logic more;       // scan pointer below entry count
        logic eval_hold;  // evaluation blocked by output register
        logic pend_valid; // a wake result is held back
        logic out_free;   // output register can take a beat
    } t_sts;

endpackage

FILE: rtl/cwt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwt_in_if
// Request channel: register sleep, register alarm or timer tick.
// ----------------------------------------------------------------------------
interface cwt_in_if;
    logic                         valid;
    logic                         ready;
    logic [cwt_pkg::OP_W-1:0]     operation;
    logic [cwt_pkg::PID_W-1:0]    process_id;
    logic [cwt_pkg::TICK_W-1:0]   tick_count;

    modport source (output valid, output operation, output process_id,
                    output tick_count, input ready);
    modport sink   (input valid, input operation, input process_id,
                    input tick_count, output ready);
endinterface

FILE: rtl/cwt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwt_out_if
// Result channel: registration status or wake notice.
// ----------------------------------------------------------------------------
interface cwt_out_if;
    logic                         valid;
    logic                         ready;
    logic [cwt_pkg::KIND_W-1:0]   result_kind;
    logic [cwt_pkg::PID_W-1:0]    process_id_res;
    logic                         raise_alarm;
    logic                         last;

    modport source (output valid, output result_kind, output process_id_res,
                    output raise_alarm, output last, input ready);
    modport sink   (input valid, input result_kind, input process_id_res,
                    input raise_alarm, input last, output ready);
endinterface

FILE: rtl/cwt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwt_datapath
// Timer table memories, scan and compaction pointers, held-back wake and
// output register.
// ----------------------------------------------------------------------------
module cwt_datapath #(
    parameter int TIMER_SLOTS = cwt_pkg::TIMER_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cwt_pkg::OP_W-1:0]      i_operation,
    input  logic [cwt_pkg::PID_W-1:0]     i_process_id,
    input  logic [cwt_pkg::TICK_W-1:0]    i_tick_count,
    input  logic                          i_out_ready,
    input  cwt_pkg::t_cmd                 i_cmd,
    output cwt_pkg::t_sts                 o_sts,
    output logic                          o_out_valid,
    output logic [cwt_pkg::KIND_W-1:0]    o_result_kind,
    output logic [cwt_pkg::PID_W-1:0]     o_process_id_res,
    output logic                          o_raise_alarm,
    output logic                          o_last
);

    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);

    logic [cwt_pkg::TICK_W-1:0] mem_ticks [TIMER_SLOTS];
    logic [cwt_pkg::PID_W-1:0]  mem_pid   [TIMER_SLOTS];
    logic                       mem_alarm [TIMER_SLOTS];

    logic [cwt_pkg::OP_W-1:0]   r_op;
    logic [cwt_pkg::PID_W-1:0]  r_pid;
    logic [cwt_pkg::TICK_W-1:0] r_cnt;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_keep, n_keep;

    logic [cwt_pkg::TICK_W-1:0] r_rd_ticks;
    logic [cwt_pkg::PID_W-1:0]  r_rd_pid;
    logic                       r_rd_alarm;

    logic                       r_pend_valid, n_pend_valid;
    logic [cwt_pkg::PID_W-1:0]  r_pend_pid, n_pend_pid;
    logic                       r_pend_alarm, n_pend_alarm;

    logic                        r_out_valid, n_out_valid;
    logic [cwt_pkg::KIND_W-1:0]  r_out_kind, n_out_kind;
    logic [cwt_pkg::PID_W-1:0]   r_out_pid, n_out_pid;
    logic                        r_out_alarm, n_out_alarm;
    logic                        r_out_last, n_out_last;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [cwt_pkg::TICK_W-1:0]  wr_ticks;
    logic [cwt_pkg::PID_W-1:0]   wr_pid;
    logic                        wr_alarm;

    logic out_free;
    logic expired;
    logic eval_hold;
    logic eval_go;
    logic full;

    assign out_free  = !r_out_valid || i_out_ready;
    assign expired   = (r_rd_ticks == '0);
    assign eval_hold = i_cmd.eval_en && expired && r_pend_valid && !out_free;
    assign eval_go   = i_cmd.eval_en && !eval_hold;
    assign full      = (r_count >= SLOTS_C);

    assign o_sts.more       = (r_rd_idx < r_count);
    assign o_sts.eval_hold  = eval_hold;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = out_free;

    always_comb begin
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_keep       = r_keep;
        n_pend_valid = r_pend_valid;
        n_pend_pid   = r_pend_pid;
        n_pend_alarm = r_pend_alarm;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_kind   = r_out_kind;
        n_out_pid    = r_out_pid;
        n_out_alarm  = r_out_alarm;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        wr_addr      = r_count[AW-1:0];
        wr_ticks     = r_cnt;
        wr_pid       = r_pid;
        wr_alarm     = (r_op == cwt_pkg::OP_ALARM);

        if (i_cmd.capture) begin
            n_rd_idx     = '0;
            n_keep       = '0;
            n_pend_valid = 1'b0;
        end

        if (i_cmd.reg_do) begin
            n_out_valid = 1'b1;
            n_out_pid   = r_pid;
            n_out_alarm = 1'b0;
            n_out_last  = 1'b1;
            if (full) begin
                n_out_kind = cwt_pkg::KIND_FULL;
            end else begin
                n_out_kind = cwt_pkg::KIND_HELD;
                wr_en      = 1'b1;
                n_count    = r_count + 1'b1;
            end
        end

        if (i_cmd.rd_en) begin
            n_rd_idx = r_rd_idx + 1'b1;
        end

        if (eval_go) begin
            if (expired) begin
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = cwt_pkg::KIND_WAKE;
                    n_out_pid   = r_pend_pid;
                    n_out_alarm = r_pend_alarm;
                    n_out_last  = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_pid   = r_rd_pid;
                n_pend_alarm = r_rd_alarm;
            end else begin
                wr_en    = 1'b1;
                wr_addr  = r_keep[AW-1:0];
                wr_ticks = r_rd_ticks - 1'b1;
                wr_pid   = r_rd_pid;
                wr_alarm = r_rd_alarm;
                n_keep   = r_keep + 1'b1;
            end
        end

        if (i_cmd.flush) begin
            n_count = r_keep;
            if (r_pend_valid && out_free) begin
                n_out_valid  = 1'b1;
                n_out_kind   = cwt_pkg::KIND_WAKE;
                n_out_pid    = r_pend_pid;
                n_out_alarm  = r_pend_alarm;
                n_out_last   = 1'b1;
                n_pend_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_ticks[wr_addr] <= wr_ticks;
            mem_pid[wr_addr]   <= wr_pid;
            mem_alarm[wr_addr] <= wr_alarm;
        end
        if (i_cmd.rd_en) begin
            r_rd_ticks <= mem_ticks[r_rd_idx[AW-1:0]];
            r_rd_pid   <= mem_pid[r_rd_idx[AW-1:0]];
            r_rd_alarm <= mem_alarm[r_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_operation;
            r_pid <= i_process_id;
            r_cnt <= i_tick_count;
        end
        r_rd_idx     <= n_rd_idx;
        r_keep       <= n_keep;
        r_pend_pid   <= n_pend_pid;
        r_pend_alarm <= n_pend_alarm;
        r_out_kind   <= n_out_kind;
        r_out_pid    <= n_out_pid;
        r_out_alarm  <= n_out_alarm;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_out_kind;
    assign o_process_id_res = r_out_pid;
    assign o_raise_alarm    = r_out_alarm;
    assign o_last           = r_out_last;

endmodule

FILE: rtl/cwt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwt_ctrl
// Sequencer: accepts requests, runs registration and the tick scan.
// ----------------------------------------------------------------------------
module cwt_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [cwt_pkg::OP_W-1:0]  i_operation,
    output logic                      o_in_ready,
    input  cwt_pkg::t_sts             i_sts,
    output cwt_pkg::t_cmd             o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_REG   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_eval, n_eval;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        n_eval        = r_eval;
        o_cmd         = '0;
        o_cmd.eval_en = r_eval;
        unique case (r_state)
            S_IDLE: begin
                n_eval = 1'b0;
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    if (i_operation == cwt_pkg::OP_SLEEP ||
                        i_operation == cwt_pkg::OP_ALARM) begin
                        n_state = S_REG;
                    end else if (i_operation == cwt_pkg::OP_TICK) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_REG: begin
                if (i_sts.out_free) begin
                    o_cmd.reg_do = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!i_sts.eval_hold) begin
                    o_cmd.rd_en = i_sts.more;
                    n_eval      = i_sts.more;
                    if (!i_sts.more && !r_eval) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                o_cmd.flush = 1'b1;
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eval  <= n_eval;
        end
    end

endmodule

FILE: rtl/countdown_wakeup_timer_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_wakeup_timer_table_top
// Table of countdown timers kept in registration order; ticks expire entries
// and emit wake beats in table order.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one request beat: register sleep, register alarm, or tick.
//   o_res carries result beats; last marks the final beat of a request.
//   A registration gives one beat (held, or rejected when the table is full)
//   from the register state once the output is free; the block then
//   returns to idle and takes the next request.
//   A tick scans the table through one memory read port, one entry per
//   cycle unless a stalled receiver holds the scan; each entry is read, then
//   evaluated and compacted in place. The drain state then commits the new
//   entry count and loads the final wake beat. A tick where nothing expires
//   gives no beat. Each wake beat is held back until the next expired entry
//   or the scan end decides its last flag.
//   One request is in work at a time; i_item.ready is high only while idle.
//   A stalled receiver freezes the scan once a second wake beat is waiting;
//   one finished beat may sit in the output register while the next request
//   is taken.
//   Reset empties the table; entry storage itself is not cleared.
// ----------------------------------------------------------------------------
module countdown_wakeup_timer_table_top #(
    parameter int TIMER_SLOTS = cwt_pkg::TIMER_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cwt_in_if.sink    i_item,
    cwt_out_if.source o_res
);

    cwt_pkg::t_cmd cmd;
    cwt_pkg::t_sts sts;

    cwt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_operation (i_item.operation),
        .o_in_ready  (i_item.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cwt_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_operation      (i_item.operation),
        .i_process_id     (i_item.process_id),
        .i_tick_count     (i_item.tick_count),
        .i_out_ready      (o_res.ready),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_res.valid),
        .o_result_kind    (o_res.result_kind),
        .o_process_id_res (o_res.process_id_res),
        .o_raise_alarm    (o_res.raise_alarm),
        .o_last           (o_res.last)
    );

endmodule
